// File: rtl/u8dv_pkg.sv
// Package for the UTF-8 stream decoder/validator.
// Holds beat types, status codes, the byte classification record and lookup functions.
// No dependencies.
package u8dv_pkg;

    localparam int COUNT_BITS  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] SHOW_MAX  = COUNT_BITS'(32'h0000ffff);

    localparam int PADDR_BITS = 3;
    localparam logic REG_SCALAR_CHECK = 1'b0;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_BAD_START  = 4'd1,
        ST_BAD_CONT   = 4'd2,
        ST_INCOMPLETE = 4'd3,
        ST_OVERLONG   = 4'd4,
        ST_SURROGATE  = 4'd5,
        ST_FFFE       = 4'd6,
        ST_FFFF       = 4'd7,
        ST_HIGH       = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        K_ASCII   = 2'd0,
        K_CONT    = 2'd1,
        K_LEAD    = 2'd2,
        K_INVALID = 2'd3
    } byte_kind_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] remaining_bytes;
    } in_beat_t;

    typedef struct packed {
        logic [30:0] code_point;
        logic [3:0]  status;
        logic [15:0] char_count;
        logic        string_end;
    } out_beat_t;

    typedef struct packed {
        byte_kind_t  kind;
        logic [2:0]  seq_len;
        logic        too_short;
        logic        last;
        logic [7:0]  data_byte;
        logic [4:0]  lead_bits;
    } cls_t;

    function automatic logic [30:0] min_for_len(input logic [2:0] len);
        logic [30:0] m;
        case (len)
            3'd2:    m = 31'h80;
            3'd3:    m = 31'h800;
            3'd4:    m = 31'h10000;
            3'd5:    m = 31'h200000;
            3'd6:    m = 31'h4000000;
            default: m = 31'h0;
        endcase
        return m;
    endfunction

    function automatic status_t scalar_status(input logic [30:0] v);
        status_t s;
        if (v >= 31'hd800 && v <= 31'hdfff) s = ST_SURROGATE;
        else if (v == 31'hfffe)             s = ST_FFFE;
        else if (v == 31'hffff)             s = ST_FFFF;
        else if (v >= 31'h110000)           s = ST_HIGH;
        else                                s = ST_OK;
        return s;
    endfunction

endpackage

// File: rtl/utf8_stream_decoder_validator.sv
// UTF-8 stream decoder/validator, top level. A result beat is registered in the back end's
// output register when its final byte leaves the queue; bytes without a result give no beat.
// Throughput: one byte per cycle, through the decode step in the back end
// behind a two-entry classified-byte queue; m_ready low stalls through the queue.
// Reset (aresetn low, synchronous): decoder state and counts cleared, queue and output
// emptied, scalar_check_enable set to 1. No clearing pass.
module utf8_stream_decoder_validator (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  u8dv_pkg::in_beat_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output u8dv_pkg::out_beat_t              m_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [u8dv_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import u8dv_pkg::*;

    logic scalar_check_enable_reg, scalar_check_enable_next;
    logic q_full, q_push, q_pop, q_valid;
    cls_t q_in, q_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SCALAR_CHECK) ? {31'b0, scalar_check_enable_reg} : '0;

    always_comb begin
        scalar_check_enable_next = scalar_check_enable_reg;
        if (psel && penable && pwrite && paddr[2] == REG_SCALAR_CHECK) begin
            scalar_check_enable_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) scalar_check_enable_reg <= 1'b1;
        else          scalar_check_enable_reg <= scalar_check_enable_next;
    end

    u8dv_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    u8dv_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_out)
    );

    u8dv_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .scalar_check_enable (scalar_check_enable_reg),
        .q_valid             (q_valid),
        .q_data              (q_out),
        .q_pop               (q_pop),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_data              (m_data)
    );

endmodule

// File: rtl/u8dv_front.sv
// Front end: accepts input beats and classifies each byte for the back end.
// Depends on u8dv_pkg.
module u8dv_front (
    input  logic              s_valid,
    output logic              s_ready,
    input  u8dv_pkg::in_beat_t s_data,
    input  logic              q_full,
    output logic              q_push,
    output u8dv_pkg::cls_t    q_data
);
    import u8dv_pkg::*;

    logic [7:0] b;

    assign b       = s_data.data_byte;
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_data           = '0;
        q_data.data_byte = b;
        q_data.last      = (s_data.remaining_bytes <= 16'd1);
        case (b) inside
            [8'h00:8'h7f]: q_data.kind = K_ASCII;
            [8'h80:8'hbf]: q_data.kind = K_CONT;
            [8'hc0:8'hdf]: begin
                q_data.kind      = K_LEAD;
                q_data.seq_len   = 3'd2;
                q_data.lead_bits = b[4:0];
            end
            [8'he0:8'hef]: begin
                q_data.kind      = K_LEAD;
                q_data.seq_len   = 3'd3;
                q_data.lead_bits = {1'b0, b[3:0]};
            end
            [8'hf0:8'hf7]: begin
                q_data.kind      = K_LEAD;
                q_data.seq_len   = 3'd4;
                q_data.lead_bits = {2'b0, b[2:0]};
            end
            [8'hf8:8'hfb]: begin
                q_data.kind      = K_LEAD;
                q_data.seq_len   = 3'd5;
                q_data.lead_bits = {3'b0, b[1:0]};
            end
            [8'hfc:8'hfd]: begin
                q_data.kind      = K_LEAD;
                q_data.seq_len   = 3'd6;
                q_data.lead_bits = {4'b0, b[0]};
            end
            default: q_data.kind = K_INVALID;
        endcase
        q_data.too_short = (s_data.remaining_bytes < 16'(q_data.seq_len));
    end

endmodule

// File: rtl/u8dv_queue.sv
// Short flop-based queue of classified bytes between front and back end.
// Depends on u8dv_pkg.
module u8dv_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  u8dv_pkg::cls_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           pop_valid,
    output u8dv_pkg::cls_t pop_data
);
    import u8dv_pkg::*;

    cls_t                 mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) cnt_next = cnt_reg + 1'b1;
        else if (pop && !push) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: rtl/u8dv_back.sv
// Back end: sequence decoder state, validation and the output register.
// Depends on u8dv_pkg.
module u8dv_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                scalar_check_enable,
    input  logic                q_valid,
    input  u8dv_pkg::cls_t      q_data,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output u8dv_pkg::out_beat_t m_data
);
    import u8dv_pkg::*;

    logic [30:0]           acc_reg, acc_next;
    logic [2:0]            pend_reg, pend_next;
    logic [2:0]            slen_reg, slen_next;
    logic                  err_reg, err_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  m_valid_reg, m_valid_next;
    out_beat_t             m_data_reg, m_data_next;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign q_pop   = q_valid && (!m_valid_reg || m_ready);

    always_comb begin
        logic                  emit;
        status_t               st;
        logic [30:0]           cp;
        logic [30:0]           acc_sh;
        logic [2:0]            pend_dec;
        logic [COUNT_BITS-1:0] cnt_inc;

        acc_next  = acc_reg;
        pend_next = pend_reg;
        slen_next = slen_reg;
        err_next  = err_reg;
        cnt_next  = cnt_reg;
        emit      = 1'b0;
        st        = ST_OK;
        cp        = '0;
        acc_sh    = {acc_reg[24:0], q_data.data_byte[5:0]};
        pend_dec  = pend_reg - 3'd1;
        cnt_inc   = cnt_reg;

        if (q_pop) begin
            if (err_reg) begin
                if (q_data.last) begin
                    acc_next  = '0;
                    pend_next = '0;
                    slen_next = '0;
                    err_next  = 1'b0;
                    cnt_next  = '0;
                end
            end else if (pend_reg == 3'd0) begin
                case (q_data.kind)
                    K_ASCII: begin
                        emit = 1'b1;
                        cp   = 31'(q_data.data_byte);
                    end
                    K_LEAD: begin
                        if (q_data.too_short) begin
                            emit = 1'b1;
                            st   = ST_INCOMPLETE;
                        end else begin
                            acc_next  = 31'(q_data.lead_bits);
                            slen_next = q_data.seq_len;
                            pend_next = q_data.seq_len - 3'd1;
                        end
                    end
                    default: begin
                        emit = 1'b1;
                        st   = ST_BAD_START;
                    end
                endcase
            end else if (q_data.kind != K_CONT) begin
                emit = 1'b1;
                st   = ST_BAD_CONT;
            end else if (pend_dec != 3'd0) begin
                if (q_data.last) begin
                    emit = 1'b1;
                    st   = ST_INCOMPLETE;
                end else begin
                    acc_next  = acc_sh;
                    pend_next = pend_dec;
                end
            end else begin
                emit = 1'b1;
                cp   = acc_sh;
                if (acc_sh < min_for_len(slen_reg)) st = ST_OVERLONG;
                else if (scalar_check_enable)       st = scalar_status(acc_sh);
                acc_next  = '0;
                pend_next = '0;
                slen_next = '0;
            end

            if (emit) begin
                if (st == ST_OK && cnt_reg != COUNT_MAX) cnt_inc = cnt_reg + 1'b1;
                cnt_next = cnt_inc;
                if (q_data.last) begin
                    acc_next  = '0;
                    pend_next = '0;
                    slen_next = '0;
                    err_next  = 1'b0;
                    cnt_next  = '0;
                end else if (st != ST_OK) begin
                    acc_next  = '0;
                    pend_next = '0;
                    slen_next = '0;
                    err_next  = 1'b1;
                end
            end
        end

        m_data_next.code_point = (st == ST_OK) ? cp : '0;
        m_data_next.status     = st;
        m_data_next.char_count = (cnt_inc > SHOW_MAX) ? 16'hffff : 16'(cnt_inc);
        m_data_next.string_end = q_data.last;

        if (q_pop && emit) m_valid_next = 1'b1;
        else if (m_ready)  m_valid_next = 1'b0;
        else               m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            pend_reg    <= '0;
            slen_reg    <= '0;
            err_reg     <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            pend_reg    <= pend_next;
            slen_reg    <= slen_next;
            err_reg     <= err_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && m_valid_next) m_data_reg <= m_data_next;
    end

    a_err_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg |-> (pend_reg == 3'd0 && slen_reg == 3'd0))
        else $error("error hold with a sequence in flight");

    a_pend_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg != 3'd0) |-> (slen_reg > pend_reg && slen_reg >= 3'd2))
        else $error("pending count exceeds sequence length");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_data.last) |=> (cnt_reg == '0 && !err_reg && pend_reg == 3'd0))
        else $error("string end did not clear decoder");

    a_err_zero_cp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status != ST_OK) |-> (m_data_reg.code_point == '0))
        else $error("error beat carries a code point");

endmodule
